### hdl/assert_macros.svh
// assertion helpers used by the rtl (csvt_parse)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked while out of reset
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// when cond holds, conseq holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed");

`endif

### hdl/csvt_pkg.sv
package csvt_pkg;

    localparam int MAX_FIELDS_DEFAULT = 1024;
    localparam int FIELD_INDEX_W      = 10;
    localparam int LINE_W             = 32;

    localparam logic [7:0] QUOTE_BYTE  = 8'h22;
    localparam logic [7:0] LF_BYTE     = 8'h0A;
    localparam logic [7:0] CR_BYTE     = 8'h0D;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_LINE_END  = 2'd2,
        KIND_TOO_MANY  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                     kind;
        logic [7:0]                data_byte;
        logic [FIELD_INDEX_W-1:0]  field_index;
        logic [LINE_W-1:0]         line_num;
    } result_t;

endpackage

### hdl/csv_field_tokenizer_top.sv
// csv field tokenizer: one raw byte in, at most one token word out
// a word appears on m_ the cycle after its byte is accepted
// one byte per cycle unless the result register stalls, set by the single result register stage
// a stalled result register holds s_ready low until m_ready frees it
// reset (aresetn low, synchronous): parser state cleared, delimiter back to comma,
// result register emptied
module csv_field_tokenizer_top #(
    parameter int MAX_FIELDS = csvt_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // delimiter write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // raw byte stream
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_in,
    // token words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [9:0]  m_field_index,
    output logic [31:0] m_line_num
);

    logic              accept;
    logic              emit;
    logic              can_take;
    csvt_pkg::result_t res;
    csvt_pkg::result_t res_out;

    // the delimiter register always takes a write
    assign cfg_ready = 1'b1;

    // a new byte goes in whenever the result slot is empty or draining
    assign s_ready = can_take;
    assign accept  = s_valid && s_ready;

    // quote, delimiter and line-end decode plus counter update
    csvt_parse #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_accept (accept),
        .in_byte   (s_byte_in),
        .res_emit  (emit),
        .res       (res)
    );

    // result register, loaded only when the byte produced a word
    csvt_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_load   (accept),
        .in_emit   (emit),
        .in_res    (res),
        .can_take  (can_take),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res_out)
    );

    assign m_kind        = res_out.kind;
    assign m_data_byte   = res_out.data_byte;
    assign m_field_index = res_out.field_index;
    assign m_line_num    = res_out.line_num;

endmodule

### hdl/csvt_parse.sv
`include "assert_macros.svh"

module csvt_parse #(
    parameter int MAX_FIELDS = csvt_pkg::MAX_FIELDS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_data,
    input  logic              in_accept,
    input  logic [7:0]        in_byte,
    output logic              res_emit,
    output csvt_pkg::result_t res
);

    localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam logic [FW-1:0] LAST_FIELD = FW'(MAX_FIELDS - 1);
    localparam int IW = csvt_pkg::FIELD_INDEX_W;
    localparam int LW = csvt_pkg::LINE_W;

    logic [7:0]    delim_reg;
    logic          inq_reg, inq_next;
    logic          pend_reg, pend_next;
    logic          pwc_reg, pwc_next;
    logic [FW-1:0] fcnt_reg, fcnt_next;
    logic [LW-1:0] lcnt_reg, lcnt_next;
    logic [FW+IW-1:0] fcnt_ext;
    logic          closes, line_end;

    assign fcnt_ext = {{IW{1'b0}}, fcnt_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_reg <= csvt_pkg::DELIM_RESET;
            inq_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            pwc_reg   <= 1'b0;
            fcnt_reg  <= '0;
            lcnt_reg  <= '0;
        end else begin
            if (cfg_we) begin
                delim_reg <= cfg_data;
            end
            if (in_accept) begin
                inq_reg  <= inq_next;
                pend_reg <= pend_next;
                pwc_reg  <= pwc_next;
                fcnt_reg <= fcnt_next;
                lcnt_reg <= lcnt_next;
            end
        end
    end

    always_comb begin
        inq_next        = inq_reg;
        pend_next       = pend_reg;
        pwc_next        = 1'b0;
        fcnt_next       = fcnt_reg;
        lcnt_next       = lcnt_reg;
        res_emit        = 1'b0;
        res.kind        = csvt_pkg::KIND_DATA;
        res.data_byte   = 8'd0;
        res.field_index = fcnt_ext[IW-1:0];
        res.line_num    = lcnt_reg + LW'(1);
        line_end        = (in_byte inside {csvt_pkg::LF_BYTE, csvt_pkg::CR_BYTE});
        closes          = !inq_reg && (line_end || in_byte == delim_reg);

        if (pwc_reg && in_byte == csvt_pkg::LF_BYTE) begin
            // lf after a line-closing cr: dropped
        end else if (in_byte == csvt_pkg::QUOTE_BYTE) begin
            inq_next = !inq_reg;
            if (pend_reg) begin
                pend_next     = 1'b0;
                res_emit      = 1'b1;
                res.data_byte = csvt_pkg::QUOTE_BYTE;
            end else begin
                pend_next = 1'b1;
            end
        end else begin
            pend_next = 1'b0;
            res_emit  = 1'b1;
            if (closes) begin
                if (fcnt_reg == LAST_FIELD) begin
                    res.kind  = csvt_pkg::KIND_TOO_MANY;
                    fcnt_next = '0;
                end else if (line_end) begin
                    res.kind  = csvt_pkg::KIND_LINE_END;
                    fcnt_next = '0;
                    lcnt_next = lcnt_reg + LW'(1);
                    pwc_next  = (in_byte == csvt_pkg::CR_BYTE);
                end else begin
                    res.kind  = csvt_pkg::KIND_FIELD_END;
                    fcnt_next = fcnt_reg + FW'(1);
                end
            end else begin
                res.data_byte = in_byte;
            end
        end
    end

    `ASSERT_HOLDS(a_fcnt_bound, aclk, aresetn, fcnt_reg <= LAST_FIELD)
    `ASSERT_NEXT(a_line_adv, aclk, aresetn,
        in_accept && res_emit && res.kind == csvt_pkg::KIND_LINE_END,
        lcnt_reg == $past(lcnt_reg) + LW'(1))
    `ASSERT_NEXT(a_err_restart, aclk, aresetn,
        in_accept && res_emit && res.kind == csvt_pkg::KIND_TOO_MANY,
        fcnt_reg == '0 && !pwc_reg && lcnt_reg == $past(lcnt_reg))

endmodule

### hdl/csvt_out_stage.sv
module csvt_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_load,
    input  logic              in_emit,
    input  csvt_pkg::result_t in_res,
    output logic              can_take,
    output logic              out_valid,
    input  logic              out_ready,
    output csvt_pkg::result_t out_res
);

    logic              valid_reg, valid_next;
    csvt_pkg::result_t res_reg;

    assign can_take  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_load) begin
            valid_next = in_emit;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && in_emit) begin
            res_reg <= in_res;
        end
    end

endmodule

### tb/sv/csv_field_tokenizer_top_tb.sv
module csv_field_tokenizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // generous bound: ~1750 bytes, each worst case a long send gap plus a long stall
    localparam int CYCLE_LIMIT = 2_000_000;
    // words appear on m_ the cycle after their byte; margin waited out after the queue drains
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES = 130;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    always #6 aclk = ~aclk;

    // every input driven from time zero
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_valid = 1'b0;
    logic [7:0]  s_byte_in = 8'h00;
    logic        m_ready = 1'b0;

    logic        cfg_ready;
    logic        s_ready;
    logic        m_valid;
    logic [1:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic [9:0]  m_field_index;
    logic [31:0] m_line_num;

    csv_field_tokenizer_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_field_index (m_field_index),
        .m_line_num    (m_line_num)
    );

    // shadow of the parser state, kept in step with accepted bytes
    logic [7:0]  delim_shadow = csvt_pkg::DELIM_RESET;
    logic        quoted_state = 1'b0;
    logic        quote_open = 1'b0;
    logic        last_cr = 1'b0;
    int unsigned field_cnt = 0;
    logic [31:0] line_cnt = 32'd0;

    csvt_pkg::result_t expected_tokens[$];
    int      mismatch_count = 0;
    int      bytes_sent = 0;
    int      cycle_count = 0;
    int      ready_stall = 0;
    // when set, the sender inserts no gaps and the result side starts no new stalls
    bit      no_idle = 1'b0;

    // gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // queue the word, if any, that one accepted byte produces
    task automatic tokenize_byte(input logic [7:0] b);
        csvt_pkg::result_t tok;
        logic    after_cr;
        logic    line_close;
        begin
            after_cr = last_cr;
            last_cr = 1'b0;
            tok.data_byte = 8'h00;
            tok.field_index = field_cnt[9:0];
            tok.line_num = line_cnt + 32'd1;
            if (after_cr && b == csvt_pkg::LF_BYTE) begin
                // lf of a crlf pair is swallowed
            end else if (b == csvt_pkg::QUOTE_BYTE) begin
                quoted_state = ~quoted_state;
                if (quote_open) begin
                    // second quote of a doubled pair
                    quote_open = 1'b0;
                    tok.kind = csvt_pkg::KIND_DATA;
                    tok.data_byte = csvt_pkg::QUOTE_BYTE;
                    expected_tokens.push_back(tok);
                end else begin
                    quote_open = 1'b1;
                end
            end else begin
                quote_open = 1'b0;
                line_close = (b == csvt_pkg::LF_BYTE || b == csvt_pkg::CR_BYTE);
                if (!quoted_state && (b == delim_shadow || line_close)) begin
                    if (field_cnt + 1 >= csvt_pkg::MAX_FIELDS_DEFAULT) begin
                        tok.kind = csvt_pkg::KIND_TOO_MANY;
                        field_cnt = 0;
                    end else if (line_close) begin
                        tok.kind = csvt_pkg::KIND_LINE_END;
                        field_cnt = 0;
                        line_cnt = line_cnt + 32'd1;
                        last_cr = (b == csvt_pkg::CR_BYTE);
                    end else begin
                        tok.kind = csvt_pkg::KIND_FIELD_END;
                        field_cnt = field_cnt + 1;
                    end
                end else begin
                    tok.kind = csvt_pkg::KIND_DATA;
                    tok.data_byte = b;
                end
                expected_tokens.push_back(tok);
            end
        end
    endtask

    // send one byte; entered and left at a falling edge, valid left high
    task automatic push_byte(input logic [7:0] b);
        int gap;
        begin
            gap = no_idle ? 0 : idle_len();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_byte_in <= b;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            tokenize_byte(b);
            bytes_sent++;
            @(negedge aclk);
        end
    endtask

    // stop sending and wait until every expected word is out
    task automatic settle_idle();
        begin
            s_valid <= 1'b0;
            while (expected_tokens.size() != 0) @(negedge aclk);
            repeat (SETTLE_CYCLES) @(negedge aclk);
        end
    endtask

    task automatic set_delimiter(input logic [7:0] value);
        begin
            settle_idle();
            cfg_valid <= 1'b1;
            cfg_data <= value;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            delim_shadow = value;
            @(negedge aclk);
            cfg_valid <= 1'b0;
        end
    endtask

    // ordinary field byte: never a quote, cr or lf, and not the delimiter unless it is 8'h61
    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = $urandom_range(0, 255);
        if (c == csvt_pkg::QUOTE_BYTE || c == csvt_pkg::CR_BYTE || c == csvt_pkg::LF_BYTE ||
            c == delim_shadow) c = 8'h61;
        return c;
    endfunction

    // one random record, mostly well formed, sometimes broken or noise
    task automatic push_record();
        int         nfields;
        int         flen;
        int         style;
        logic [7:0] c;
        begin
            no_idle = ($urandom_range(0, 9) == 0);
            style = $urandom_range(0, 99);
            if (style < 12) begin
                // raw noise over the whole byte range
                repeat ($urandom_range(1, 12)) push_byte($urandom_range(0, 255));
            end else begin
                nfields = $urandom_range(1, 6);
                for (int f = 0; f < nfields; f++) begin
                    flen = $urandom_range(0, 6);
                    if ($urandom_range(0, 2) == 0) begin
                        // quoted field with escaped quotes and embedded specials
                        push_byte(csvt_pkg::QUOTE_BYTE);
                        for (int i = 0; i < flen; i++) begin
                            case ($urandom_range(0, 9))
                                0: c = csvt_pkg::QUOTE_BYTE;
                                1: c = delim_shadow;
                                2: c = csvt_pkg::CR_BYTE;
                                3: c = csvt_pkg::LF_BYTE;
                                default: c = $urandom_range(0, 255);
                            endcase
                            push_byte(c);
                            if (c == csvt_pkg::QUOTE_BYTE) push_byte(csvt_pkg::QUOTE_BYTE);
                        end
                        // an unterminated quote now and then
                        if (style < 95) push_byte(csvt_pkg::QUOTE_BYTE);
                    end else begin
                        for (int i = 0; i < flen; i++) push_byte(plain_byte());
                    end
                    if (f != nfields - 1) push_byte(delim_shadow);
                end
                case ($urandom_range(0, 2))
                    0: push_byte(csvt_pkg::LF_BYTE);
                    1: push_byte(csvt_pkg::CR_BYTE);
                    default: begin
                        push_byte(csvt_pkg::CR_BYTE);
                        push_byte(csvt_pkg::LF_BYTE);
                    end
                endcase
            end
        end
    endtask

    // comma after reset: byte extremes, field ends, empty fields, crlf
    task automatic test_default_delimiter();
        begin
            push_byte(8'h00);
            push_byte(8'hFF);
            push_byte(8'h61);
            push_byte(csvt_pkg::DELIM_RESET);
            push_byte(csvt_pkg::DELIM_RESET);
            push_byte(csvt_pkg::LF_BYTE);
            push_byte(csvt_pkg::CR_BYTE);
            // lf right after a line-closing cr is dropped
            push_byte(csvt_pkg::LF_BYTE);
            push_byte(csvt_pkg::LF_BYTE);
        end
    endtask

    // quoted fields: embedded delimiter and line breaks, doubled and third quotes
    task automatic test_quoting();
        begin
            push_byte(csvt_pkg::QUOTE_BYTE);
            push_byte(csvt_pkg::DELIM_RESET);
            push_byte(csvt_pkg::CR_BYTE);
            push_byte(csvt_pkg::LF_BYTE);
            push_byte(csvt_pkg::QUOTE_BYTE);
            push_byte(csvt_pkg::DELIM_RESET);
            // three quotes in a row, then a byte inside the reopened quote
            push_byte(csvt_pkg::QUOTE_BYTE);
            push_byte(csvt_pkg::QUOTE_BYTE);
            push_byte(csvt_pkg::QUOTE_BYTE);
            push_byte(8'h62);
            push_byte(csvt_pkg::QUOTE_BYTE);
            push_byte(csvt_pkg::CR_BYTE);
        end
    endtask

    // quote as delimiter never closes; cr as delimiter still ends the line
    task automatic test_delimiter_settings();
        begin
            set_delimiter(csvt_pkg::QUOTE_BYTE);
            push_byte(8'h78);
            push_byte(csvt_pkg::QUOTE_BYTE);
            push_byte(8'h79);
            push_byte(csvt_pkg::QUOTE_BYTE);
            push_byte(csvt_pkg::LF_BYTE);
            set_delimiter(csvt_pkg::CR_BYTE);
            push_byte(8'h61);
            push_byte(csvt_pkg::CR_BYTE);
            push_byte(csvt_pkg::LF_BYTE);
        end
    endtask

    // a line with too many fields, closed by cr
    task automatic test_field_overflow();
        begin
            set_delimiter(csvt_pkg::DELIM_RESET);
            repeat (csvt_pkg::MAX_FIELDS_DEFAULT - 1) push_byte(csvt_pkg::DELIM_RESET);
            push_byte(csvt_pkg::CR_BYTE);
            // error clears the cr flag, so this lf ends a line
            push_byte(csvt_pkg::LF_BYTE);
            push_byte(8'h7A);
            push_byte(csvt_pkg::LF_BYTE);
        end
    endtask

    // random records under several delimiters, extremes included
    task automatic test_random_records();
        int         start;
        logic [7:0] delims[5];
        begin
            delims[0] = csvt_pkg::DELIM_RESET;
            delims[1] = 8'h00;
            delims[2] = 8'hFF;
            delims[3] = 8'h09;
            delims[4] = $urandom_range(0, 255);
            foreach (delims[p]) begin
                set_delimiter(delims[p]);
                start = bytes_sent;
                while (bytes_sent < start + PHASE_BYTES) push_record();
            end
            no_idle = 1'b0;
        end
    endtask

    function automatic void report_field(input string name, input longint want,
                                         input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // result side stalls: mostly ready, random short and long holds
    always @(negedge aclk) begin
        if (ready_stall > 0) begin
            ready_stall = ready_stall - 1;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            ready_stall = idle_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // every accepted word against the oldest expected one
    always @(posedge aclk) begin : word_check
        csvt_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                $display({"%0t: unexpected word, expected none ",
                          "actual kind %0d data %0h field %0d line %0d"},
                         $time, m_kind, m_data_byte, m_field_index, m_line_num);
                mismatch_count++;
            end else begin
                want = expected_tokens.pop_front();
                report_field("kind", want.kind, m_kind);
                report_field("data_byte", want.data_byte, m_data_byte);
                report_field("field_index", want.field_index, m_field_index);
                report_field("line_num", want.line_num, m_line_num);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words still expected", $time,
                     expected_tokens.size());
            $display("csv_field_tokenizer_top verification failed");
            $finish;
        end
    end

    initial begin
        // single reset at the start
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_delimiter();
        test_quoting();
        test_delimiter_settings();
        test_field_overflow();
        test_random_records();

        // drain, then wait out the settle margin for anything stray
        settle_idle();
        if (mismatch_count == 0) begin
            $display("csv_field_tokenizer_top verification clean");
        end else begin
            $display("csv_field_tokenizer_top verification failed");
        end
        $finish;
    end

endmodule
